[rtl/core/slm_pkg.sv]
// slm_pkg: shared constants and types for the sorted list merge block.
// Used by slm_list_store and sorted_list_merge; depends on nothing.
package slm_pkg;

    localparam int LIST_DEPTH_DEFAULT = 16;
    localparam int VALUE_W            = 32;
    localparam int OPCODE_W           = 2;

    localparam logic [OPCODE_W-1:0] OP_APPEND_A = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_APPEND_B = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MERGE    = 2'd2;

    // write-side control of one list store
    typedef struct packed {
        logic append;
        logic clear;
    } t_list_ctrl;

endpackage

[rtl/core/slm_list_store.sv]
// slm_list_store: one list memory with element count and registered read port.
// Depends on slm_pkg for the value width and the control struct.
module slm_list_store #(
    parameter int DEPTH = slm_pkg::LIST_DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  slm_pkg::t_list_ctrl                i_ctrl,
    input  logic signed [slm_pkg::VALUE_W-1:0] i_value,
    input  logic [AW-1:0]                      i_rd_idx,
    output logic signed [slm_pkg::VALUE_W-1:0] o_rd_data,
    output logic [CW-1:0]                      o_count,
    output logic                               o_full
);

    logic signed [slm_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic signed [slm_pkg::VALUE_W-1:0] r_rd_data;
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      n_count;
    logic                               w_full;

    assign w_full = (r_count == CW'(DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_ctrl.clear) begin
            n_count = '0;
        end else if (i_ctrl.append && !w_full) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.append && !w_full) begin
            r_mem[r_count[AW-1:0]] <= i_value;
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;
    assign o_full    = w_full;

endmodule

[rtl/core/sorted_list_merge.sv]
// sorted_list_merge: top level, command decode and merge sequencer over two list stores.
// Depends on slm_pkg and slm_list_store.
// Appends are taken one per cycle while not busy. For each merged element the heads
// are read via the registered store ports in ST_READ, then compared and registered
// out in ST_EMIT; busy holds until the last element is emitted; an empty merge never
// raises busy and strobes its single result the cycle after it is accepted.
// Reset (synchronous, active low) empties both lists and clears the overflow flag.
// Results are strobed for one cycle on o_result_valid; the receiver cannot stall.
module sorted_list_merge #(
    parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [slm_pkg::OPCODE_W-1:0]        i_opcode,
    input  logic signed [slm_pkg::VALUE_W-1:0]  i_item_value,
    output logic                                o_result_valid,
    output logic signed [slm_pkg::VALUE_W-1:0]  o_merged_value,
    output logic                                o_last_of_run,
    output logic                                o_empty_merge,
    output logic                                o_overflow_seen
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                         r_state, n_state;
    logic [CW-1:0]                      r_ia, n_ia;
    logic [CW-1:0]                      r_ib, n_ib;
    logic                               r_ovf, n_ovf;
    logic                               r_valid, n_valid;
    logic signed [slm_pkg::VALUE_W-1:0] r_value, n_value;
    logic                               r_last, n_last;
    logic                               r_empty, n_empty;
    logic                               r_ovf_out, n_ovf_out;

    slm_pkg::t_list_ctrl                w_ctrl_a, w_ctrl_b;
    logic signed [slm_pkg::VALUE_W-1:0] w_rd_a, w_rd_b;
    logic [CW-1:0]                      w_cnt_a, w_cnt_b;
    logic                               w_full_a, w_full_b;
    logic                               w_accept;
    logic                               w_have_a, w_have_b, w_take_a;
    logic [CW-1:0]                      w_ia_inc, w_ib_inc;

    slm_list_store #(.DEPTH(LIST_DEPTH), .AW(AW), .CW(CW)) u_list_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl_a),
        .i_value  (i_item_value),
        .i_rd_idx (r_ia[AW-1:0]),
        .o_rd_data(w_rd_a),
        .o_count  (w_cnt_a),
        .o_full   (w_full_a)
    );

    slm_list_store #(.DEPTH(LIST_DEPTH), .AW(AW), .CW(CW)) u_list_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl_b),
        .i_value  (i_item_value),
        .i_rd_idx (r_ib[AW-1:0]),
        .o_rd_data(w_rd_b),
        .o_count  (w_cnt_b),
        .o_full   (w_full_b)
    );

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign w_have_a = (r_ia < w_cnt_a);
    assign w_have_b = (r_ib < w_cnt_b);
    // on a tie the B head goes first
    assign w_take_a = w_have_a && (!w_have_b || (w_rd_a < w_rd_b));
    assign w_ia_inc = r_ia + CW'(1);
    assign w_ib_inc = r_ib + CW'(1);

    always_comb begin
        n_state   = r_state;
        n_ia      = r_ia;
        n_ib      = r_ib;
        n_ovf     = r_ovf;
        n_valid   = 1'b0;
        n_value   = r_value;
        n_last    = r_last;
        n_empty   = r_empty;
        n_ovf_out = r_ovf_out;
        w_ctrl_a  = '0;
        w_ctrl_b  = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        slm_pkg::OP_APPEND_A: begin
                            w_ctrl_a.append = 1'b1;
                            if (w_full_a) begin
                                n_ovf = 1'b1;
                            end
                        end
                        slm_pkg::OP_APPEND_B: begin
                            w_ctrl_b.append = 1'b1;
                            if (w_full_b) begin
                                n_ovf = 1'b1;
                            end
                        end
                        slm_pkg::OP_MERGE: begin
                            if ((w_cnt_a == '0) && (w_cnt_b == '0)) begin
                                n_valid   = 1'b1;
                                n_value   = '0;
                                n_last    = 1'b1;
                                n_empty   = 1'b1;
                                n_ovf_out = r_ovf;
                                n_ovf     = 1'b0;
                            end else begin
                                n_ia    = '0;
                                n_ib    = '0;
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                // heads at r_ia / r_ib are registered out of the stores this cycle
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_valid   = 1'b1;
                n_empty   = 1'b0;
                n_ovf_out = r_ovf;
                if (w_take_a) begin
                    n_value = w_rd_a;
                    n_ia    = w_ia_inc;
                    n_last  = (w_ia_inc == w_cnt_a) && !w_have_b;
                end else begin
                    n_value = w_rd_b;
                    n_ib    = w_ib_inc;
                    n_last  = (w_ib_inc == w_cnt_b) && !w_have_a;
                end
                if (n_last) begin
                    w_ctrl_a.clear = 1'b1;
                    w_ctrl_b.clear = 1'b1;
                    n_ovf          = 1'b0;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ia    <= '0;
            r_ib    <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ia    <= n_ia;
            r_ib    <= n_ib;
            r_ovf   <= n_ovf;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_last    <= n_last;
        r_empty   <= n_empty;
        r_ovf_out <= n_ovf_out;
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_result_valid  = r_valid;
    assign o_merged_value  = r_value;
    assign o_last_of_run   = r_last;
    assign o_empty_merge   = r_empty;
    assign o_overflow_seen = r_ovf_out;

endmodule
